// File: sv/rcm_pkg.sv
// Shared constants, types and command/status bundles for the resolution clause merge block.
`default_nettype none
package rcm_pkg;

  // Literal variable width kept internally and clause storage size
  localparam int VAR_BITS    = 16;
  localparam int MAX_LITS    = 32;
  localparam int STORE_DEPTH = 32;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int KEY_W       = VAR_BITS + 1;
  localparam int PORT_VAR_W  = 16;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [VAR_BITS-1:0] var_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;  // input item taken this cycle
    logic fetch;   // read the heads of both clause stores
    logic pick;    // compare the heads and advance one list
    logic flush;   // emit the closing item of the run
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic more;       // literals remain in either list
    logic pick_go;    // the pick step completes this cycle
    logic slot_free;  // output register can take an item
  } sts_t;

endpackage
`default_nettype wire

// File: sv/rcm_ctrl.sv
// Controller state machine for the resolution clause merge block.
`default_nettype none
module rcm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          start_merge,
  input  wire rcm_pkg::sts_t sts,
  output logic               in_ready,
  output rcm_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_PICK  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Take items only while loading
  assign in_ready   = (state_r == ST_LOAD);
  assign cmd.accept = in_valid && in_ready;
  assign cmd.fetch  = (state_r == ST_FETCH) && sts.more;
  assign cmd.pick   = (state_r == ST_PICK);
  assign cmd.flush  = (state_r == ST_FLUSH);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (cmd.accept && start_merge) state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        state_nxt = sts.more ? ST_PICK : ST_FLUSH;
      end
      ST_PICK: begin
        if (sts.pick_go) state_nxt = ST_FETCH;
      end
      ST_FLUSH: begin
        if (sts.slot_free) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/rcm_dpath.sv
// Datapath: clause stores, load counters, merge pointers and output register.
`default_nettype none
module rcm_dpath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire rcm_pkg::cmd_t                   cmd,
  output rcm_pkg::sts_t                        sts,
  input  wire logic                            in_clause_sel,
  input  wire logic [rcm_pkg::PORT_VAR_W-1:0]  in_lit_var,
  input  wire logic                            in_lit_sign,
  input  wire logic [rcm_pkg::PORT_VAR_W-1:0]  in_pivot_var,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [rcm_pkg::PORT_VAR_W-1:0]       out_var,
  output logic                                 out_sign,
  output logic                                 out_empty_clause,
  output logic                                 out_overflow,
  output logic                                 out_last_out
);

  // Clause stores
  rcm_pkg::key_t mem_a [rcm_pkg::STORE_DEPTH];
  rcm_pkg::key_t mem_b [rcm_pkg::STORE_DEPTH];
  rcm_pkg::key_t rd_a_r, rd_b_r;

  // Load state
  rcm_pkg::cnt_t cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  rcm_pkg::var_t pivot_r, pivot_nxt;
  logic          ovf_r, ovf_nxt;
  logic          loaded_r, loaded_nxt;
  logic          wr_a, wr_b;
  rcm_pkg::key_t in_key;

  // Merge state
  rcm_pkg::cnt_t i_r, i_nxt, j_r, j_nxt;
  rcm_pkg::key_t prev_r, prev_nxt;
  logic          have_prev_r, have_prev_nxt;

  // Output register
  logic                               ov_r, ov_nxt;
  logic [rcm_pkg::PORT_VAR_W-1:0]     ovar_r, ovar_nxt;
  logic                               osign_r, osign_nxt;
  logic                               oempty_r, oempty_nxt;
  logic                               oovf_r, oovf_nxt;
  logic                               olast_r, olast_nxt;

  // Pick logic
  logic          a_left, b_left, take_a, kept, slot_free, pick_go, push;
  rcm_pkg::key_t cand;

  localparam rcm_pkg::cnt_t CntMax = rcm_pkg::cnt_t'(rcm_pkg::MAX_LITS);

  assign in_key = {in_lit_var[rcm_pkg::VAR_BITS-1:0], in_lit_sign};

  // Compare heads and filter the candidate
  always_comb begin
    a_left    = (i_r < cnt_a_r);
    b_left    = (j_r < cnt_b_r);
    take_a    = a_left && (!b_left || (rd_a_r < rd_b_r));
    cand      = take_a ? rd_a_r : rd_b_r;
    kept      = (cand[rcm_pkg::KEY_W-1:1] != pivot_r) && !(have_prev_r && (cand == prev_r));
    slot_free = !ov_r || out_ready;
    pick_go   = !(kept && have_prev_r) || slot_free;
  end

  assign sts.more      = a_left || b_left;
  assign sts.pick_go   = pick_go;
  assign sts.slot_free = slot_free;

  // Next-state logic for load, merge and output
  always_comb begin
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    pivot_nxt     = pivot_r;
    ovf_nxt       = ovf_r;
    loaded_nxt    = loaded_r;
    wr_a          = 1'b0;
    wr_b          = 1'b0;
    i_nxt         = i_r;
    j_nxt         = j_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    push          = 1'b0;
    ovar_nxt      = ovar_r;
    osign_nxt     = osign_r;
    oempty_nxt    = oempty_r;
    oovf_nxt      = oovf_r;
    olast_nxt     = olast_r;

    // Load one literal
    if (cmd.accept) begin
      if (!in_clause_sel) begin
        if (!loaded_r) begin
          pivot_nxt = in_pivot_var[rcm_pkg::VAR_BITS-1:0];
          cnt_a_nxt = '0;
          cnt_b_nxt = '0;
          ovf_nxt   = 1'b0;
        end
        loaded_nxt = 1'b1;
        if (cnt_a_nxt < CntMax) begin
          wr_a      = 1'b1;
          cnt_a_nxt = cnt_a_nxt + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
      end else begin
        if (cnt_b_r < CntMax) begin
          wr_b      = 1'b1;
          cnt_b_nxt = cnt_b_r + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      i_nxt         = '0;
      j_nxt         = '0;
      have_prev_nxt = 1'b0;
    end

    // Advance one list; hold the kept literal back until the next one shows
    if (cmd.pick && pick_go) begin
      if (take_a) i_nxt = i_r + 1'b1;
      else        j_nxt = j_r + 1'b1;
      if (kept) begin
        if (have_prev_r) begin
          push       = 1'b1;
          ovar_nxt   = rcm_pkg::PORT_VAR_W'(prev_r[rcm_pkg::KEY_W-1:1]);
          osign_nxt  = prev_r[0];
          oempty_nxt = 1'b0;
          oovf_nxt   = ovf_r;
          olast_nxt  = 1'b0;
        end
        prev_nxt      = cand;
        have_prev_nxt = 1'b1;
      end
    end

    // Close the run and clear the round
    if (cmd.flush && slot_free) begin
      push       = 1'b1;
      oovf_nxt   = ovf_r;
      olast_nxt  = 1'b1;
      oempty_nxt = !have_prev_r;
      if (have_prev_r) begin
        ovar_nxt  = rcm_pkg::PORT_VAR_W'(prev_r[rcm_pkg::KEY_W-1:1]);
        osign_nxt = prev_r[0];
      end else begin
        ovar_nxt  = '0;
        osign_nxt = 1'b0;
      end
      cnt_a_nxt  = '0;
      cnt_b_nxt  = '0;
      ovf_nxt    = 1'b0;
      loaded_nxt = 1'b0;
    end

    ov_nxt = push || (ov_r && !out_ready);
  end

  // Clause store writes and registered head reads
  always_ff @(posedge clk) begin
    if (wr_a) mem_a[cnt_a_r[rcm_pkg::IDX_W-1:0] & {rcm_pkg::IDX_W{loaded_r}}] <= in_key;
    if (wr_b) mem_b[cnt_b_r[rcm_pkg::IDX_W-1:0]] <= in_key;
    if (cmd.fetch) begin
      rd_a_r <= mem_a[i_r[rcm_pkg::IDX_W-1:0]];
      rd_b_r <= mem_b[j_r[rcm_pkg::IDX_W-1:0]];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      pivot_r     <= '0;
      ovf_r       <= 1'b0;
      loaded_r    <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      have_prev_r <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      pivot_r     <= pivot_nxt;
      ovf_r       <= ovf_nxt;
      loaded_r    <= loaded_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      have_prev_r <= have_prev_nxt;
      ov_r        <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prev_r   <= prev_nxt;
    ovar_r   <= ovar_nxt;
    osign_r  <= osign_nxt;
    oempty_r <= oempty_nxt;
    oovf_r   <= oovf_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_valid        = ov_r;
  assign out_var          = ovar_r;
  assign out_sign         = osign_r;
  assign out_empty_clause = oempty_r;
  assign out_overflow     = oovf_r;
  assign out_last_out     = olast_r;

endmodule
`default_nettype wire

// File: sv/resolution_clause_merge_core.sv
// The last literal of the second clause starts the merge, one step per stored literal, then a
// closing step; the final item waits in the flush state while out_ready holds the output full.
// Loading takes one literal per cycle while the block is in its load state; the merge reads both
// clause stores through a registered port; each step is a fetch, then a compare that can stall.
// No input item is taken while a merge runs. Synchronous active-low reset clears counts, pivot,
// flags and state; clause stores are not cleared and no clearing pass is needed.
`default_nettype none
module resolution_clause_merge_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_clause_sel,
  input  wire logic [rcm_pkg::PORT_VAR_W-1:0]  in_lit_var,
  input  wire logic                            in_lit_sign,
  input  wire logic                            in_last_lit,
  input  wire logic [rcm_pkg::PORT_VAR_W-1:0]  in_pivot_var,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [rcm_pkg::PORT_VAR_W-1:0]       out_var,
  output logic                                 out_sign,
  output logic                                 out_empty_clause,
  output logic                                 out_overflow,
  output logic                                 out_last_out
);

  rcm_pkg::cmd_t cmd;
  rcm_pkg::sts_t sts;

  // Sequence load, merge and flush
  rcm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .start_merge (in_clause_sel && in_last_lit),
    .sts         (sts),
    .in_ready    (in_ready),
    .cmd         (cmd)
  );

  // Store clauses and produce the resolvent
  rcm_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_clause_sel    (in_clause_sel),
    .in_lit_var       (in_lit_var),
    .in_lit_sign      (in_lit_sign),
    .in_pivot_var     (in_pivot_var),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_var          (out_var),
    .out_sign         (out_sign),
    .out_empty_clause (out_empty_clause),
    .out_overflow     (out_overflow),
    .out_last_out     (out_last_out)
  );

endmodule
`default_nettype wire
